[sv/assert_macros.svh]
// Assertion macros for the RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_IMPL(lbl, clk, rst_n, ante, cons)
`define CHK_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/sha256_pkg.sv]
// SHA-256 constants and round helper functions.
// No dependencies.
package sha256_pkg;
  typedef logic [31:0] word_t;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
    32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
    32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
    32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
    32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
    32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
    32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
    32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
    32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LENGTH_POS = 6'd56;

  function automatic word_t ror(input word_t x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t ssig0(input word_t x);
    ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t ssig1(input word_t x);
    ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t bsig0(input word_t x);
    bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
  endfunction

  function automatic word_t bsig1(input word_t x);
    bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
  endfunction
endpackage

[sv/sha256_byte_stream_hasher_top.sv]
// SHA-256 byte stream hasher, top level.
// Uses sha256_pkg and assert_macros.svh.
//
// Input items (in_valid / in_stall): in_data_byte, in_byte_valid,
// in_end_of_message. End closes the message, with or without a byte; an
// item with neither flag is dropped. Output items (out_valid / out_stall):
// out_digest_word, out_word_index, out_last_word, eight per message, word 0
// first.
// A byte is written to a 64-entry buffer memory. The 64th byte
// starts a compression: a load phase (one buffer read per cycle into a
// 16-word schedule window), 64 rounds at one per cycle, and a fold step.
// No byte is taken while a compression runs.
// End of message writes the padding one byte per cycle, then runs one or
// two compressions and sends the eight words.
// in_stall is high whenever the block is busy; out_stall only holds the
// current word, and no input is taken until all eight words have gone.
// Reset (rst_n low, synchronous) reloads the initial hash and clears the
// byte and bit counts; buffer entries are always written before read.
`include "assert_macros.svh"

module sha256_byte_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_byte_valid,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;  // write padding bytes
  localparam logic [2:0] S_LOAD  = 3'd2;  // bytes -> words
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FOLD  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [6:0]  fill_r, fill_nxt;      // bytes held; 127 while padding
  logic [63:0] bits_r, bits_nxt;
  logic        final_r, final_nxt;    // current compression closes message
  logic        len_blk_r, len_blk_nxt;// padding block carries length
  logic [5:0]  pos_r, pos_nxt;
  logic [7:0]  cnt_r, cnt_nxt;        // load/round counter
  logic [3:0]  oidx_r, oidx_nxt;
  sha256_pkg::word_t h_r [8];
  sha256_pkg::word_t v_r [8];
  sha256_pkg::word_t acc_r;
  sha256_pkg::word_t wwin_r [16];     // message schedule window

  // byte buffer memory
  logic [7:0] buf_mem [64];
  logic       buf_we;
  logic [5:0] buf_wa, buf_ra;
  logic [7:0] buf_wd, buf_rd_r;

  always_ff @(posedge clk) begin
    if (buf_we) buf_mem[buf_wa] <= buf_wd;
    buf_rd_r <= buf_mem[buf_ra];
  end

  logic take;
  assign in_stall = (state_r != S_IDLE);
  assign take     = in_valid && !in_stall;

  // padding byte for position p
  logic [7:0] pad_byte;
  always_comb begin
    if (len_blk_r && pos_r >= sha256_pkg::LENGTH_POS)
      pad_byte = bits_r[8 * (7 - pos_r[2:0]) +: 8];
    else
      pad_byte = 8'h00;
  end

  // round datapath
  sha256_pkg::word_t w_cur, t1, t2, w_new;
  always_comb begin
    w_cur = wwin_r[0];
    w_new = sha256_pkg::ssig1(wwin_r[14]) + wwin_r[9] +
            sha256_pkg::ssig0(wwin_r[1]) + wwin_r[0];
    t1 = v_r[7] + sha256_pkg::bsig1(v_r[4]) +
         ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) +
         sha256_pkg::ROUND_K[cnt_r[5:0]] + w_cur;
    t2 = sha256_pkg::bsig0(v_r[0]) +
         ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    bits_nxt    = bits_r;
    final_nxt   = final_r;
    len_blk_nxt = len_blk_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    oidx_nxt    = oidx_r;
    buf_we      = 1'b0;
    buf_wa      = fill_r[5:0];
    buf_wd      = in_data_byte;
    buf_ra      = cnt_r[5:0];
    unique case (state_r)
      S_IDLE: begin
        if (take) begin
          if (in_byte_valid) begin
            buf_we   = 1'b1;
            fill_nxt = fill_r + 7'd1;
            bits_nxt = bits_r + 64'd8;
          end
          final_nxt = in_end_of_message;
          if (in_byte_valid && fill_r == 7'd63) begin
            state_nxt = S_LOAD;
            cnt_nxt   = '0;
            fill_nxt  = '0;
          end else if (in_end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        // first cycle: write 0x80 at fill, then zeros / length up to 63
        buf_we = 1'b1;
        if (fill_r != 7'd127) begin
          buf_wa      = fill_r[5:0];
          buf_wd      = sha256_pkg::PAD_MARK;
          len_blk_nxt = (fill_r[5:0] < sha256_pkg::LENGTH_POS);
          pos_nxt     = fill_r[5:0] + 6'd1;
          fill_nxt    = 7'd127;
          if (fill_r[5:0] == 6'd63) begin
            state_nxt = S_LOAD;
            cnt_nxt   = '0;
          end
        end else begin
          buf_wa  = pos_r;
          buf_wd  = pad_byte;
          pos_nxt = pos_r + 6'd1;
          if (pos_r == 6'd63) begin
            state_nxt = S_LOAD;
            cnt_nxt   = '0;
          end
        end
      end
      S_LOAD: begin
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == 8'd64) begin
          state_nxt = S_ROUND;
          cnt_nxt   = '0;
        end
      end
      S_ROUND: begin
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == 8'd63) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        fill_nxt = '0;
        if (!final_r) begin
          state_nxt = S_IDLE;
        end else if (fill_r == 7'd127 && !len_blk_r) begin
          // second padding block: zeros then length
          len_blk_nxt = 1'b1;
          pos_nxt     = '0;
          fill_nxt    = 7'd127;
          state_nxt   = S_PAD;
        end else if (fill_r != 7'd127) begin
          state_nxt = S_PAD;   // full block then end: start padding
        end else begin
          state_nxt = S_OUT;
          oidx_nxt  = '0;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          oidx_nxt = oidx_r + 4'd1;
          if (oidx_r == 4'd7) begin
            state_nxt = S_IDLE;
            fill_nxt  = '0;
            bits_nxt  = '0;
            final_nxt = 1'b0;
            len_blk_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fill_r    <= '0;
      bits_r    <= '0;
      final_r   <= 1'b0;
      len_blk_r <= 1'b0;
      pos_r     <= '0;
      cnt_r     <= '0;
      oidx_r    <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::H_INIT[i];
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      bits_r    <= bits_nxt;
      final_r   <= final_nxt;
      len_blk_r <= len_blk_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      oidx_r    <= oidx_nxt;
      if (state_r == S_FOLD)
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      if (state_r == S_OUT && !out_stall && oidx_r == 4'd7)
        for (int i = 0; i < 8; i++) h_r[i] <= sha256_pkg::H_INIT[i];
    end
  end

  // load: buffer read data is registered, so it lands in the cycle after address cnt
  always_ff @(posedge clk) begin
    if (state_r == S_LOAD && cnt_r != 8'd0) begin
      acc_r <= {acc_r[23:0], buf_rd_r};
      if (cnt_r[1:0] == 2'd0) begin
        for (int i = 0; i < 15; i++) wwin_r[i] <= wwin_r[i + 1];
        wwin_r[15] <= {acc_r[23:0], buf_rd_r};
      end
    end else if (state_r == S_ROUND) begin
      for (int i = 0; i < 15; i++) wwin_r[i] <= wwin_r[i + 1];
      wwin_r[15] <= w_new;
    end
    if (state_r == S_LOAD) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (state_r == S_ROUND) begin
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign out_valid       = (state_r == S_OUT);
  assign out_digest_word = h_r[oidx_r[2:0]];
  assign out_word_index  = oidx_r[2:0];
  assign out_last_word   = (oidx_r[2:0] == 3'd7);

  `CHK_IMPL(a_no_take_busy, clk, rst_n, state_r != S_IDLE, !take)
  `CHK_IMPL(a_oidx_range, clk, rst_n, out_valid, oidx_r[3] == 1'b0)
  `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `CHK_IMPL(a_round_cnt, clk, rst_n, state_r == S_ROUND, cnt_r < 8'd64)
endmodule

[dv/sha256_byte_stream_hasher_top_tb.sv]
// Self-checking testbench for sha256_byte_stream_hasher_top.
// Depends on sha256_pkg (H_INIT, ROUND_K, PAD_MARK, LENGTH_POS) and the RTL top.
// Streams messages byte by byte and checks every digest word against an
// in-bench SHA-256 model.
module sha256_byte_stream_hasher_top_tb;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;
  } byte_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_byte_valid;
  logic        in_end_of_message;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha256_byte_stream_hasher_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data_byte(in_data_byte), .in_byte_valid(in_byte_valid),
    .in_end_of_message(in_end_of_message),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  // Clock: period 20.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Hash model state.
  sha256_pkg::word_t hash_state [8];
  logic [7:0] msg_block  [64];
  int         fill_cnt;
  logic [63:0] bit_cnt;

  byte_item_t   pending_bytes [$];
  digest_item_t expected_words [$];

  int  mismatch_cnt;
  int  digest_cnt;
  int  byte_cnt;
  bit  calm_phase;    // last stretch: no idling on either side
  bit  hold_sender;   // sender waits until all expected words have drained
  int  in_gap;
  int  out_gap;
  int  idle_cycles;

  localparam int WATCHDOG_LIMIT = 20000;

  function automatic sha256_pkg::word_t rotr(sha256_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One 64-round compression of msg_block into hash_state.
  task automatic compress_block();
    sha256_pkg::word_t w [64];
    sha256_pkg::word_t v [8];
    sha256_pkg::word_t t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    v = hash_state;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  // Absorb one accepted item; on end of message queue the eight digest words.
  task automatic absorb_item(byte_item_t it);
    int pos;
    if (it.byte_valid) begin
      msg_block[fill_cnt] = it.data_byte;
      fill_cnt++;
      bit_cnt += 64'd8;
      if (fill_cnt == 64) begin
        compress_block();
        fill_cnt = 0;
      end
    end
    if (!it.end_of_message) return;
    pos = fill_cnt;
    msg_block[pos++] = sha256_pkg::PAD_MARK;
    if (pos > int'(sha256_pkg::LENGTH_POS)) begin
      while (pos < 64) msg_block[pos++] = 8'h00;
      compress_block();
      pos = 0;
    end
    while (pos < int'(sha256_pkg::LENGTH_POS)) msg_block[pos++] = 8'h00;
    for (int k = 7; k >= 0; k--) msg_block[pos++] = bit_cnt[8*k +: 8];
    compress_block();
    for (int k = 0; k < 8; k++)
      expected_words.push_back('{digest_word: hash_state[k], word_index: 3'(k),
                                 last_word: (k == 7)});
    hash_state = sha256_pkg::H_INIT;
    fill_cnt   = 0;
    bit_cnt    = '0;
  endtask

  // Append a message of n random bytes; end rides on the last byte or a bare mark.
  task automatic push_message(int n, bit bare_end);
    for (int i = 0; i < n; i++)
      pending_bytes.push_back('{data_byte: 8'($urandom), byte_valid: 1'b1,
                                end_of_message: (!bare_end && i == n - 1)});
    if (bare_end || n == 0)
      pending_bytes.push_back('{data_byte: 8'($urandom), byte_valid: 1'b0,
                                end_of_message: 1'b1});
  endtask

  // Driver: pops the next item when the current one is taken or none is up.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) byte_cnt <= byte_cnt + 1;
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (pending_bytes.size() == 0 ||
                   (hold_sender && expected_words.size() != 0)) begin
        in_valid <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        in_gap   <= $urandom_range(0, 7);
      end else begin
        byte_item_t it;
        it = pending_bytes.pop_front();
        in_valid          <= 1'b1;
        in_data_byte      <= it.data_byte;
        in_byte_valid     <= it.byte_valid;
        in_end_of_message <= it.end_of_message;
      end
    end
  end

  // Predict at acceptance so expectations are queued in order.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      absorb_item('{data_byte: in_data_byte, byte_valid: in_byte_valid,
                    end_of_message: in_end_of_message});
  end

  // Result side: random stall bursts, compare each accepted word.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap   <= out_gap - 1;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        out_gap   <= $urandom_range(0, 7);
      end else begin
        out_stall <= 1'b0;
      end
      if (out_valid && !out_stall) begin
        digest_item_t got, want;
        got = '{digest_word: out_digest_word, word_index: out_word_index,
                last_word: out_last_word};
        digest_cnt <= digest_cnt + 1;
        if (expected_words.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: unexpected digest item %h/%0d/%0d",
                     got.digest_word, got.word_index, got.last_word);
        end else begin
          want = expected_words.pop_front();
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("ERROR: digest item exp %h/%0d/%0d got %h/%0d/%0d",
                       want.digest_word, want.word_index, want.last_word,
                       got.digest_word, got.word_index, got.last_word);
          end
        end
      end
    end
  end

  // Watchdog: cycles without any accepted item on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout after %0d idle cycles", idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int n_msgs;
    int len;
    rst_n = 1'b0;
    in_valid = 1'b0; in_data_byte = '0; in_byte_valid = 1'b0;
    in_end_of_message = 1'b0; out_stall = 1'b0;
    hash_state = sha256_pkg::H_INIT; fill_cnt = 0; bit_cnt = '0;
    for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
    mismatch_cnt = 0; digest_cnt = 0; byte_cnt = 0; idle_cycles = 0;
    calm_phase = 0; hold_sender = 0; in_gap = 0; out_gap = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, byte 00/ff with end, a dropped item,
    // and short messages of 3, 1 and 5 bytes.
    push_message(0, 1'b1);
    pending_bytes.push_back('{data_byte: 8'hff, byte_valid: 1'b0, end_of_message: 1'b0});
    pending_bytes.push_back('{data_byte: 8'h00, byte_valid: 1'b1, end_of_message: 1'b1});
    pending_bytes.push_back('{data_byte: 8'hff, byte_valid: 1'b1, end_of_message: 1'b1});
    push_message(3, 1'b1);
    push_message(1, 1'b0);
    push_message(5, 1'b0);

    // Drain once with the sender held.
    hold_sender = 1;
    wait (pending_bytes.size() == 0 && expected_words.size() == 0);
    @(posedge clk);
    hold_sender = 0;

    // Boundary lengths: 55, 56, 63, 64 bytes (one or two pad blocks).
    push_message(55, 1'b0);
    push_message(56, 1'b1);
    push_message(63, 1'b0);
    push_message(64, 1'b1);

    // Random messages, mostly short, with stray dropped items.
    n_msgs = 0;
    while (n_msgs < 14) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 70) : $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0)
        pending_bytes.push_back('{data_byte: 8'($urandom), byte_valid: 1'b0,
                                  end_of_message: 1'b0});
      push_message(len, 1'($urandom_range(0, 1)) || len == 0);
      n_msgs++;
      if (n_msgs == 11) begin
        wait (pending_bytes.size() == 0);
        calm_phase = 1;
      end
    end

    wait (pending_bytes.size() == 0);
    wait (!in_valid);
    wait (expected_words.size() == 0);
    repeat (400) @(posedge clk);

    $display("Covered %0d input items and %0d digest words over directed and random",
             byte_cnt, digest_cnt);
    $display("messages (empty, pad-boundary lengths, bare ends, dropped items).");
    if (mismatch_cnt == 0 && expected_words.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Mismatches: %0d, words still expected: %0d",
               mismatch_cnt, expected_words.size());
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

[sim.f]
+incdir+sv
sv/sha256_pkg.sv
sv/sha256_byte_stream_hasher_top.sv
dv/sha256_byte_stream_hasher_top_tb.sv
